// File: rtl/cwd_pkg.sv
// shared types and constants for the cobs word deframer
package cwd_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned WORD_LANES     = WORD_W / BYTE_W;
  localparam int unsigned WORD_BYTES_DEF = 4;

  localparam logic [BYTE_W-1:0] CODE_DELIM      = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_FULL_BLOCK = 8'hFF;

  // decoded word handed from the decode core to the output stage
  typedef struct packed {
    logic              emit;
    logic [WORD_W-1:0] word;
  } cwd_emit_t;

endpackage

// File: rtl/cwd_core.sv
// cobs decode state and word packing, one link byte per transfer
module cwd_core
  import cwd_pkg::*;
#(
  parameter int unsigned WORD_BYTES = WORD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_fire,
  input  logic [BYTE_W-1:0] byte_in,
  output cwd_emit_t         emit_o
);

  localparam int unsigned SLOT_W = $clog2(WORD_BYTES + 1);
  localparam int unsigned LANES  = (WORD_BYTES < WORD_LANES) ? WORD_BYTES : WORD_LANES;
  localparam logic [SLOT_W-1:0] SLOT_IDLE = SLOT_W'(WORD_BYTES);
  localparam logic [SLOT_W-1:0] SLOT_TOP  = SLOT_W'(WORD_BYTES - 1);

  logic [BYTE_W-1:0] block_rem_r, block_rem_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [WORD_W-1:0] part_r, part_nxt;
  logic              iz_r, iz_nxt;

  logic              place;
  logic [BYTE_W-1:0] place_val;
  logic [SLOT_W-1:0] place_slot;
  logic [WORD_W-1:0] placed_word;

  // effective slot, awaiting frame start folds to the top slot
  assign place_slot = (slot_r >= SLOT_IDLE) ? SLOT_TOP : slot_r;

  always_comb begin
    placed_word = part_r;
    for (int k = 0; k < LANES; k++) begin
      if (place_slot == SLOT_W'(k)) begin
        placed_word[k*BYTE_W +: BYTE_W] = place_val;
      end
    end
  end

  always_comb begin
    block_rem_nxt = block_rem_r;
    slot_nxt      = slot_r;
    part_nxt      = part_r;
    iz_nxt        = iz_r;
    place         = 1'b0;
    place_val     = byte_in;
    emit_o.emit   = 1'b0;
    emit_o.word   = placed_word;
    if (byte_fire) begin
      if (byte_in == CODE_DELIM) begin
        block_rem_nxt = '0;
        slot_nxt      = SLOT_IDLE;
        part_nxt      = '0;
        iz_nxt        = 1'b0;
      end else if (block_rem_r == '0) begin
        // code byte opens a block
        block_rem_nxt = byte_in - BYTE_W'(1);
        iz_nxt        = (byte_in != CODE_FULL_BLOCK);
        place_val     = '0;
        if (slot_r >= SLOT_IDLE) begin
          slot_nxt = SLOT_TOP;
          part_nxt = '0;
        end else begin
          place = iz_r;
        end
      end else begin
        block_rem_nxt = block_rem_r - BYTE_W'(1);
        place         = 1'b1;
      end
      if (place) begin
        if (place_slot == '0) begin
          emit_o.emit = 1'b1;
          part_nxt    = '0;
          slot_nxt    = SLOT_TOP;
        end else begin
          part_nxt = placed_word;
          slot_nxt = place_slot - SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_rem_r <= '0;
      slot_r      <= SLOT_IDLE;
      part_r      <= '0;
      iz_r        <= 1'b0;
    end else begin
      block_rem_r <= block_rem_nxt;
      slot_r      <= slot_nxt;
      part_r      <= part_nxt;
      iz_r        <= iz_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_IDLE)
    else $error("byte slot out of range");

  a_delim_clears: assert property (@(posedge clk) disable iff (!rst_n)
    byte_fire && byte_in == CODE_DELIM |=>
      slot_r == SLOT_IDLE && block_rem_r == '0 && part_r == '0 && !iz_r)
    else $error("delimiter did not clear frame state");

  a_emit_cause: assert property (@(posedge clk) disable iff (!rst_n)
    emit_o.emit |-> byte_fire && byte_in != CODE_DELIM && slot_r != SLOT_IDLE)
    else $error("word emitted without a decoded byte");

  a_emit_restart: assert property (@(posedge clk) disable iff (!rst_n)
    emit_o.emit |=> slot_r == SLOT_TOP && part_r == '0)
    else $error("word position not restarted after emission");
`endif

endmodule

// File: rtl/cwd_out_stage.sv
// result register for decoded words, decouples the receiver stall
module cwd_out_stage
  import cwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cwd_emit_t         emit_i,
  output logic              ready_o,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata
);

  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] word_r;

  // slot frees up in the same cycle the held word is taken
  assign ready_o    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (emit_i.emit) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_i.emit) begin
      word_r <= emit_i.word;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_i.emit |-> ready_o)
    else $error("word emitted while result register is blocked");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r && !emit_i.emit |=> !valid_r)
    else $error("result valid without an emitted word");
`endif

endmodule

// File: rtl/cobs_word_deframer_unit.sv
// top level of the cobs word deframer: link bytes in, decoded 32-bit words out
//
// usage:
//   in_*  : one cobs-framed link byte per transfer in in_tdata[7:0]; a zero
//           byte is the frame delimiter and ends the frame
//   out_* : one decoded word per transfer, first received byte in bits 31:24
//           (the top byte lane for the configured word size)
//   a word is registered and offered in the cycle after the transfer that
//   carries its last byte; one input byte is taken every cycle while
//   in_tready is high, so the rate is one byte per cycle, set by the single
//   decode pass between the state registers and the result register
//   a code byte inserts an implied zero byte unless it opens the frame or
//   follows a full block code; a partial word is dropped at a delimiter
//   reset: nothing pending, waiting for a frame start; the first nonzero byte
//   seen is taken as the frame's opening code
//   stall: while a word waits and out_tready is low, in_tready drops; it
//   stays high when the waiting word is taken in the same cycle
module cobs_word_deframer_unit
  import cwd_pkg::*;
#(
  parameter int unsigned WORD_BYTES = WORD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // byte stream in
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] serial_byte
  // decoded word stream out
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata   // [31:0] word
);

  cwd_emit_t emit;
  logic      stage_ready;
  logic      byte_fire;

  assign in_tready = stage_ready;
  assign byte_fire = in_tvalid && stage_ready;

  // frame state, block count and word packing
  cwd_core #(
    .WORD_BYTES(WORD_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_fire(byte_fire),
    .byte_in  (in_tdata),
    .emit_o   (emit)
  );

  // result register
  cwd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_i    (emit),
    .ready_o   (stage_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// File: test/cobs_word_deframer_unit_check.sv
// checker for the cobs word deframer: watches both streams, predicts words and compares
module cobs_word_deframer_unit_check
  import cwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [WORD_W-1:0] out_tdata,
  output int                error_count,
  output int                words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LANES = WORD_BYTES_DEF;
  localparam int PRINT_CAP = 30;

  // predictor state
  logic [BYTE_W-1:0] run_left;
  logic [2:0]        lane;
  logic [WORD_W-1:0] word_acc;
  logic              zero_owed;
  logic [WORD_W-1:0] expected_words[$];

  initial begin
    error_count = 0;
    words_due = 0;
  end

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (error_count < PRINT_CAP)
      $display("%0t ns mismatch: %s got %08h want %08h", $time, what, got, want);
    error_count = error_count + 1;
  endtask

  task automatic clear_frame();
    run_left = '0;
    lane = 3'(LANES);
    word_acc = '0;
    zero_owed = 1'b0;
  endtask

  // drop one decoded byte into its lane, msb lane first
  task automatic place_lane(input logic [BYTE_W-1:0] value);
    logic [2:0] at;
    at = (lane >= LANES) ? 3'(LANES - 1) : lane;
    word_acc = word_acc | (WORD_W'(value) << (BYTE_W * at));
    if (at == 3'd0) begin
      expected_words.push_back(word_acc);
      word_acc = '0;
      lane = 3'(LANES - 1);
    end else begin
      lane = at - 3'd1;
    end
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] link_byte);
    logic zero_now;
    if (link_byte == CODE_DELIM) begin
      clear_frame();
    end else if (run_left == '0) begin
      // code byte: opens a block, maybe owes a zero from the last one
      zero_now = zero_owed;
      run_left = link_byte - 8'd1;
      zero_owed = (link_byte != CODE_FULL_BLOCK);
      if (lane >= LANES) begin
        lane = 3'(LANES - 1);
        word_acc = '0;
      end else if (zero_now) begin
        place_lane('0);
      end
    end else begin
      run_left = run_left - 8'd1;
      place_lane(link_byte);
    end
  endtask

  always @(posedge clk) begin : watch
    logic [WORD_W-1:0] want;
    if (!rst_n) begin
      clear_frame();
      expected_words.delete();
    end else begin
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with none expected", out_tdata, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_tdata !== want) report_mismatch("word", out_tdata, want);
        end
      end
    end
    words_due <= expected_words.size();
  end

endmodule

// File: test/cobs_word_deframer_unit_test.sv
// top of the cobs word deframer test: clock, reset, byte stimulus, word sink and verdict
module cobs_word_deframer_unit_test
  import cwd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT    = 23;    // percent of cycles each side sits out
  localparam int LINK_TARGET = 500;   // opening, one full block and random frames, in bytes
  localparam int STUCK_LIMIT = 400;   // cycles with no transfer before giving up
  localparam int HOLD_START  = 200;   // receiver cycle where the long hold-off begins
  localparam int HOLD_LEN    = 80;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata = '0;   // [7:0] serial_byte
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [WORD_W-1:0] out_tdata;       // [31:0] word
  int                error_count;
  int                words_due;

  logic [BYTE_W-1:0] link_bytes[$];

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cobs_word_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  cobs_word_deframer_unit_check check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .error_count (error_count),
    .words_due   (words_due)
  );

  // append one cobs frame made of random blocks, closed by a delimiter;
  // a cut-short frame can stop mid block and then gets its delimiter early
  task automatic add_frame(input bit cut_short, input bit full_block);
    int budget;
    int blocks;
    int code;
    int pick;
    budget = cut_short ? $urandom_range(1, 8) : 32'h4000_0000;
    blocks = full_block ? $urandom_range(2, 6) : $urandom_range(1, 6);
    for (int k = 0; k < blocks && budget > 0; k++) begin
      pick = $urandom_range(0, 99);
      if (full_block && k == 0) code = int'(CODE_FULL_BLOCK);
      else if (pick < 6) code = $urandom_range(10, 40);
      else code = $urandom_range(1, 9);
      link_bytes.push_back(BYTE_W'(code));
      budget--;
      for (int j = 1; j < code && budget > 0; j++) begin
        link_bytes.push_back(BYTE_W'($urandom_range(1, 255)));
        budget--;
      end
    end
    link_bytes.push_back(CODE_DELIM);
  endtask

  // sender: builds the byte stream, then offers it with random gaps
  initial begin : sender
    int idx;
    int kind;
    bit calm;
    // opening bytes, joined midstream with no leading delimiter:
    //   03 opens the frame, 02 owes a zero -> 11220033
    //   two empty blocks add zeros, then the delimiter drops the partial word
    //   fresh frame with extreme data -> ff807f01
    //   empty blocks back to back -> 000000aa
    //   a second delimiter right after the first
    //   alternating ff/zero, partial word left at the delimiter
    link_bytes = '{8'h03, 8'h11, 8'h22, 8'h02, 8'h33,
                   8'h01, 8'h01, CODE_DELIM,
                   8'h05, 8'hFF, 8'h80, 8'h7F, 8'h01,
                   8'h01, 8'h01, 8'h02, 8'hAA, CODE_DELIM,
                   CODE_DELIM,
                   8'h02, 8'hFF, 8'h02, 8'hFF, 8'h02, 8'hFF, CODE_DELIM};
    // first random frame carries a full block so a code follows a 0xff code
    add_frame(1'b0, 1'b1);
    while (link_bytes.size() < LINK_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        add_frame(1'b0, 1'b0);
      end else if (kind < 90) begin
        add_frame(1'b1, 1'b0);
      end else begin
        // line noise, zeros now and then, no closing delimiter
        repeat ($urandom_range(1, 10))
          link_bytes.push_back(($urandom_range(0, 7) == 0) ? CODE_DELIM
                                                            : BYTE_W'($urandom_range(1, 255)));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    while (idx < link_bytes.size()) begin
      @(posedge clk);
      if (in_tvalid && in_tready) idx++;
      // a stretch of the stream goes out with no gaps at all
      calm = (idx >= 350 && idx < 470);
      if (in_tvalid && !in_tready) begin
        // transfer still pending: keep offering the same byte
      end else if (idx < link_bytes.size() &&
                   (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= link_bytes[idx];
      end else begin
        in_tvalid <= 1'b0;
      end
    end

    // words_due is registered, so step the clock before looking at it
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    // let a trailing partial frame settle before the verdict
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("cobs_word_deframer_unit_test: done, clean");
    end else begin
      $display("cobs_word_deframer_unit_test: done, errors");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so the block backs up
  // into in_tready, and a stretch that takes every word at once
  initial begin : receiver
    int cyc;
    cyc = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
        out_tready <= 1'b0;
      else if (cyc >= 500 && cyc < 650)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog: too long with no transfer on either side ends the run
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        stuck = 0;
      else
        stuck++;
    end
    $display("cobs_word_deframer_unit_test: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/cwd_pkg.sv
rtl/cwd_core.sv
rtl/cwd_out_stage.sv
rtl/cobs_word_deframer_unit.sv
test/cobs_word_deframer_unit_check.sv
test/cobs_word_deframer_unit_test.sv
